@@ hw/rtl/nbsb_pkg.sv @@
package nbsb_pkg;

    localparam int SIG_WORDS = 5;
    localparam int WORD_W    = 64;
    localparam int ADDR_W    = $clog2(SIG_WORDS);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int SIG_BITS  = SIG_WORDS * WORD_W;

    localparam int BYTE_W    = 8;
    localparam int PRED_W    = 15;
    localparam int OFF_W     = 8;
    localparam int TWIN_W    = 16;
    localparam int SQ_W      = 2 * PRED_W;
    localparam int P3_W      = PRED_W + 2;

    localparam int DIV_W     = 32;
    localparam int CNT_W     = 2;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 72;
    localparam int REQ_W      = 2;

    localparam logic [7:0]  HASH_SEED = 8'd131;
    localparam logic [30:0] HASH_MASK = 31'h7FFF_FFFF;
    localparam logic [1:0]  PRED_SEED = 2'd3;
    localparam logic [7:0]  SKIP_CHAR = 8'h3F;

    typedef enum logic [REQ_W-1:0] {
        REQ_LABEL = 2'd0,
        REQ_PRED  = 2'd1,
        REQ_READ  = 2'd2
    } t_req;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MOD  = 5'b00010,
        S_SET  = 5'b00100,
        S_RD   = 5'b01000,
        S_LD   = 5'b10000
    } t_state;

endpackage

@@ hw/rtl/ngram_bloom_signature_builder_unit.sv @@
// Bloom-style vertex signature builder. Each transfer on the slave side is one request, its kind
// in tuser: a label byte, a predicate id or a readout. A label byte that closes no trigram is
// handled in the idle state alone; one that sets a bit is hashed, reduced in three steps (a
// reciprocal multiply, a multiply back with subtract, then a compare and subtract that also
// issues the signature memory read) and written back. A byte whose bit falls beyond storage
// skips the write back. A predicate takes two reductions and up to two read-modify-writes in
// turn. A readout sends the five 64-bit words on the master side, each by a memory read, then
// a load into the output register that waits while the sink stalls, and leaves the signature
// clear. Bit indexes of 320 or more are dropped.
module ngram_bloom_signature_builder_unit
    import nbsb_pkg::*;
#(
    parameter int ENTITY_BITS = 256,
    parameter int PRED_BITS   = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // label_byte[7:0], pred_id[22:8], hash_offset[30:23]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // req_type[1:0]
    input  logic [REQ_W-1:0]      i_s_tuser,
    // label_end
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // sig_word[63:0], word_index[66:64]
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // last_word
    output logic                  o_m_tlast
);

    localparam int MAX_MOD = (ENTITY_BITS > PRED_BITS) ? ENTITY_BITS : PRED_BITS;
    localparam int REM_W   = $clog2(MAX_MOD) + 1;
    localparam int IDX_W   = (REM_W + 1 > 10) ? REM_W + 1 : 10;
    localparam logic [DIV_W-1:0] RCP_ENT  = DIV_W'((64'd1 << DIV_W) / 64'(ENTITY_BITS));
    localparam logic [DIV_W-1:0] RCP_PRED = DIV_W'((64'd1 << DIV_W) / 64'(PRED_BITS));

    t_state                r_state, n_state;
    logic [BYTE_W-1:0]     r_newer, n_newer;
    logic [TWIN_W-1:0]     r_twin, n_twin;
    logic [1:0]            r_seen, n_seen;
    logic                  r_skip, n_skip;
    logic                  r_start, n_start;
    logic [DIV_W-1:0]      r_div, n_div;
    logic [DIV_W-1:0]      r_quot, n_quot;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_is_pred, n_is_pred;
    logic                  r_pend, n_pend;
    logic [SQ_W-1:0]       r_sq, n_sq;
    logic [P3_W-1:0]       r_p3off, n_p3off;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic [ADDR_W-1:0]     r_widx, n_widx;
    logic                  r_out_valid, n_out_valid;
    logic [WORD_W-1:0]     r_out_word, n_out_word;
    logic [ADDR_W-1:0]     r_out_idx, n_out_idx;
    logic                  r_out_last, n_out_last;

    logic [WORD_W-1:0]     r_mem [SIG_WORDS];
    logic [SIG_WORDS-1:0]  r_valid;
    logic [WORD_W-1:0]     r_rd_data;
    logic                  r_rd_vld;

    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic                  mem_we;
    logic [WORD_W-1:0]     mem_wdata;
    logic                  clr_en;

    logic                  s_xfer;
    t_req                  req;
    logic [BYTE_W-1:0]     in_byte;
    logic [PRED_W-1:0]     in_pred;
    logic [OFF_W-1:0]      in_off;
    logic                  lbl_skip;
    logic [1:0]            lbl_seen;
    logic [23:0]           hash_prod;
    logic [30:0]           hash_val;
    logic [REM_W-1:0]      mod_val;
    logic [DIV_W-1:0]      rcp_val;
    logic [DIV_W-1:0]      quot_est;
    logic [DIV_W-1:0]      rem_raw;
    logic [REM_W-1:0]      rem_fix;
    logic [IDX_W-1:0]      bit_idx;
    logic [WORD_W-1:0]     rd_word;
    logic                  out_free;

    assign s_xfer  = i_s_tvalid && o_s_tready;
    assign req     = t_req'(i_s_tuser);
    assign in_byte = i_s_tdata[BYTE_W-1:0];
    assign in_pred = i_s_tdata[BYTE_W +: PRED_W];
    assign in_off  = i_s_tdata[BYTE_W+PRED_W +: OFF_W];

    assign lbl_skip  = r_start ? (in_byte == SKIP_CHAR) : r_skip;
    assign lbl_seen  = r_start ? 2'd0 : r_seen;
    assign hash_prod = 24'(r_twin) * 24'(HASH_SEED);
    assign hash_val  = (31'(hash_prod) + 31'(in_byte)) & HASH_MASK;

    assign mod_val = r_is_pred ? REM_W'(PRED_BITS) : REM_W'(ENTITY_BITS);
    assign rcp_val = r_is_pred ? RCP_PRED : RCP_ENT;

    // reciprocal estimate is low by at most one, fixed by one compare and subtract
    assign quot_est = DIV_W'(((2*DIV_W)'(r_div) * (2*DIV_W)'(rcp_val)) >> DIV_W);
    assign rem_raw  = r_div - DIV_W'(r_quot * DIV_W'(mod_val));
    assign rem_fix  = (r_rem >= mod_val) ? r_rem - mod_val : r_rem;

    assign bit_idx  = (r_is_pred ? IDX_W'(ENTITY_BITS) : IDX_W'(0)) + IDX_W'(rem_fix);
    assign rd_word  = r_rd_vld ? r_rd_data : '0;
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_newer     = r_newer;
        n_twin      = r_twin;
        n_seen      = r_seen;
        n_skip      = r_skip;
        n_start     = r_start;
        n_div       = r_div;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_is_pred   = r_is_pred;
        n_pend      = r_pend;
        n_sq        = r_sq;
        n_p3off     = r_p3off;
        n_addr      = r_addr;
        n_bit       = r_bit;
        n_widx      = r_widx;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        mem_re      = 1'b0;
        mem_raddr   = r_addr;
        mem_we      = 1'b0;
        mem_wdata   = rd_word | (WORD_W'(1) << r_bit);
        clr_en      = 1'b0;
        o_s_tready  = 1'b0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (s_xfer) begin
                    n_cnt = '0;
                    unique case (req)
                        REQ_LABEL: begin
                            n_skip  = lbl_skip;
                            n_seen  = (lbl_seen < 2'd2) ? lbl_seen + 2'd1 : lbl_seen;
                            n_start = i_s_tlast;
                            n_newer = in_byte;
                            n_twin  = TWIN_W'(16'(r_newer) * 16'(HASH_SEED))
                                      + TWIN_W'(in_byte);
                            if (lbl_seen == 2'd2 && !lbl_skip) begin
                                n_div     = DIV_W'(hash_val) + DIV_W'(in_off);
                                n_is_pred = 1'b0;
                                n_pend    = 1'b0;
                                n_state   = S_MOD;
                            end
                        end
                        REQ_PRED: begin
                            n_div     = DIV_W'(in_pred) + DIV_W'(in_off);
                            n_sq      = SQ_W'(in_pred) * SQ_W'(in_pred);
                            n_p3off   = P3_W'(in_pred) * P3_W'(PRED_SEED) + P3_W'(in_off);
                            n_is_pred = 1'b1;
                            n_pend    = 1'b1;
                            n_state   = S_MOD;
                        end
                        REQ_READ: begin
                            n_widx  = '0;
                            n_state = S_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOD: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(0)) begin
                    n_quot = quot_est;
                end else if (r_cnt == CNT_W'(1)) begin
                    n_rem = rem_raw[REM_W-1:0];
                end else begin
                    n_addr = bit_idx[BIT_W +: ADDR_W];
                    n_bit  = bit_idx[BIT_W-1:0];
                    if (bit_idx < IDX_W'(SIG_BITS)) begin
                        mem_re    = 1'b1;
                        mem_raddr = bit_idx[BIT_W +: ADDR_W];
                        n_state   = S_SET;
                    end else if (r_pend) begin
                        n_div   = DIV_W'(r_sq) + DIV_W'(r_p3off);
                        n_cnt   = '0;
                        n_pend  = 1'b0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SET: begin
                mem_we = 1'b1;
                if (r_pend) begin
                    n_div   = DIV_W'(r_sq) + DIV_W'(r_p3off);
                    n_cnt   = '0;
                    n_pend  = 1'b0;
                    n_state = S_MOD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_widx;
                n_state   = S_LD;
            end
            S_LD: begin
                if (out_free) begin
                    clr_en      = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_word  = rd_word;
                    n_out_idx   = r_widx;
                    n_out_last  = (r_widx == ADDR_W'(SIG_WORDS - 1));
                    if (r_widx == ADDR_W'(SIG_WORDS - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_widx  = r_widx + ADDR_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_newer     <= '0;
            r_twin      <= '0;
            r_seen      <= '0;
            r_skip      <= 1'b0;
            r_start     <= 1'b1;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_is_pred   <= 1'b0;
            r_widx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_newer     <= n_newer;
            r_twin      <= n_twin;
            r_seen      <= n_seen;
            r_skip      <= n_skip;
            r_start     <= n_start;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_is_pred   <= n_is_pred;
            r_widx      <= n_widx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div      <= n_div;
        r_quot     <= n_quot;
        r_rem      <= n_rem;
        r_sq       <= n_sq;
        r_p3off    <= n_p3off;
        r_addr     <= n_addr;
        r_bit      <= n_bit;
        r_out_word <= n_out_word;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    // signature memory, entries not valid read as zero
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
            r_rd_vld  <= r_valid[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (mem_we) begin
                r_valid[r_addr] <= 1'b1;
            end
            if (clr_en) begin
                r_valid[r_widx] <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DATA_W - WORD_W - ADDR_W)'(0), r_out_idx, r_out_word};
    assign o_m_tlast  = r_out_last;

endmodule

@@ hw/rtl/nbsb_checker.sv @@
module nbsb_checker
    import nbsb_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [IN_DATA_W-1:0]  i_s_tdata,
    input logic [REQ_W-1:0]      i_s_tuser,
    input logic                  i_s_tlast,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output payload changed while stalled");

    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tdata[WORD_W +: ADDR_W] == ADDR_W'(SIG_WORDS - 1))))
        else $error("last flag does not match final word index");

    a_readout_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("request accepted in the middle of a readout");

endmodule

bind ngram_bloom_signature_builder_unit nbsb_checker u_nbsb_checker (.*);

@@ test/ngram_bloom_signature_builder_checker.sv @@
module ngram_bloom_signature_builder_checker
    import nbsb_pkg::*;
#(
    parameter int ENTITY_BITS = 256,
    parameter int PRED_BITS   = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // label_byte[7:0], pred_id[22:8], hash_offset[30:23]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // req_type[1:0]
    input  logic [REQ_W-1:0]      i_s_tuser,
    // label_end
    input  logic                  i_s_tlast,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // sig_word[63:0], word_index[66:64]
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    // last_word
    input  logic                  i_m_tlast,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_words_checked
);

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [2:0]        index;
        logic              last;
    } sig_beat_t;

    sig_beat_t         expected_beats[$];
    logic [WORD_W-1:0] sig_model[SIG_WORDS];
    logic [7:0]        win_old;
    logic [7:0]        win_new;
    logic [1:0]        win_fill;
    logic              win_skip;
    logic              label_start;

    function automatic void set_sig_bit(bit [63:0] pos);
        if (pos < 64'(SIG_BITS)) begin
            sig_model[pos / WORD_W][pos % WORD_W] = 1'b1;
        end
    endfunction

    function automatic void take_label_byte(logic [7:0] c, logic last, logic [7:0] off);
        bit [31:0] trigram;
        if (label_start) begin
            win_skip = (c == SKIP_CHAR);
            win_fill = 2'd0;
        end
        if (win_fill >= 2'd2 && !win_skip) begin
            trigram = (32'(win_old) * 32'(HASH_SEED) + 32'(win_new)) * 32'(HASH_SEED)
                      + 32'(c);
            trigram = trigram & 32'(HASH_MASK);
            set_sig_bit((64'(trigram) + 64'(off)) % 64'(ENTITY_BITS));
        end
        win_old = win_new;
        win_new = c;
        if (win_fill < 2'd2) begin
            win_fill = win_fill + 2'd1;
        end
        label_start = last;
    endfunction

    function automatic void take_predicate(logic [PRED_W-1:0] pred, logic [7:0] off);
        bit [63:0] p;
        p = 64'(pred);
        set_sig_bit(64'(ENTITY_BITS) + (p + 64'(off)) % 64'(PRED_BITS));
        set_sig_bit(64'(ENTITY_BITS)
                    + (p * p + 64'(PRED_SEED) * p + 64'(off)) % 64'(PRED_BITS));
    endfunction

    function automatic void read_and_clear();
        for (int k = 0; k < SIG_WORDS; k++) begin
            expected_beats.push_back('{word: sig_model[k], index: 3'(k),
                                       last: (k == SIG_WORDS - 1)});
            sig_model[k] = '0;
        end
    endfunction

    always @(posedge i_clk) begin
        sig_beat_t got;
        sig_beat_t want;
        if (!i_rst_n) begin
            expected_beats.delete();
            for (int k = 0; k < SIG_WORDS; k++) begin
                sig_model[k] = '0;
            end
            win_old         = '0;
            win_new         = '0;
            win_fill        = '0;
            win_skip        = 1'b0;
            label_start     = 1'b1;
            o_fail_count    = 0;
            o_words_checked = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.word  = i_m_tdata[WORD_W-1:0];
                got.index = i_m_tdata[WORD_W+2:WORD_W];
                got.last  = i_m_tlast;
                o_words_checked++;
                if (expected_beats.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("unexpected word transfer: word %h index %0d last %b",
                                 got.word, got.index, got.last);
                    end
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("word mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                                     want.word, want.index, want.last,
                                     got.word, got.index, got.last);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == REQ_LABEL) begin
                    take_label_byte(i_s_tdata[7:0], i_s_tlast, i_s_tdata[30:23]);
                end else if (i_s_tuser == REQ_PRED) begin
                    take_predicate(i_s_tdata[22:8], i_s_tdata[30:23]);
                end else if (i_s_tuser == REQ_READ) begin
                    read_and_clear();
                end
            end
        end
        o_pending = expected_beats.size();
    end

endmodule

@@ test/ngram_bloom_signature_builder_unit_test.sv @@
module ngram_bloom_signature_builder_unit_test;
    import nbsb_pkg::*;

    localparam int ENTITY_BITS  = 256;
    localparam int PRED_BITS    = 64;
    localparam int RANDOM_ITEMS = 158;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 40;
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [REQ_W-1:0]      s_tuser  = REQ_LABEL;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    int fail_count;
    int pending_words;
    int words_checked;
    int cycle_count = 0;
    int label_bytes = 0;
    int predicates  = 0;
    int readouts    = 0;
    int unknowns    = 0;
    bit no_gaps     = 1'b0;

    ngram_bloom_signature_builder_unit #(
        .ENTITY_BITS(ENTITY_BITS),
        .PRED_BITS  (PRED_BITS)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .i_s_tlast (s_tlast),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tlast (m_tlast)
    );

    ngram_bloom_signature_builder_checker #(
        .ENTITY_BITS(ENTITY_BITS),
        .PRED_BITS  (PRED_BITS)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_s_tlast      (s_tlast),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tlast      (m_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending_words),
        .o_words_checked(words_checked)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_words);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sink back-pressure
    always @(negedge clk) begin
        m_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 19);
    end

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_item(input logic [REQ_W-1:0] req, input logic [7:0] c,
                             input logic last, input logic [PRED_W-1:0] pred,
                             input logic [OFF_W-1:0] off);
        while (!no_gaps && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, off, pred, c};
        s_tuser  <= req;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        if (req == REQ_LABEL) begin
            label_bytes++;
        end else if (req == REQ_PRED) begin
            predicates++;
        end else if (req == REQ_READ) begin
            readouts++;
        end else begin
            unknowns++;
        end
    endtask

    task automatic send_byte(input logic [7:0] c, input logic last, input logic [7:0] off);
        send_item(REQ_LABEL, c, last, PRED_W'($urandom), off);
    endtask

    task automatic send_pred(input logic [PRED_W-1:0] pred, input logic [7:0] off);
        send_item(REQ_PRED, 8'($urandom), 1'($urandom), pred, off);
    endtask

    task automatic send_readout();
        send_item(REQ_READ, 8'($urandom), 1'($urandom), PRED_W'($urandom), OFF_W'($urandom));
    endtask

    task automatic send_unknown();
        send_item(REQ_NONE, 8'($urandom), 1'($urandom), PRED_W'($urandom), OFF_W'($urandom));
    endtask

    task automatic send_label(input int len, input bit closed);
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            c = (i == 0 && $urandom_range(99) < 15) ? SKIP_CHAR : 8'($urandom);
            send_byte(c, closed && (i == len - 1), 8'($urandom));
        end
    endtask

    task automatic wait_for_words();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending_words != 0);
    endtask

    initial begin
        int  random_done;
        int  pick;
        int  len;
        bit  mid_drain_done;
        random_done    = 0;
        mid_drain_done = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed
        send_readout();
        send_byte(8'hFF, 1'b0, 8'hFF);
        send_byte(8'hFF, 1'b0, 8'hFF);
        send_byte(8'hFF, 1'b1, 8'hFF);
        send_byte(8'h00, 1'b0, 8'h00);
        send_byte(8'h00, 1'b0, 8'h00);
        send_byte(8'h00, 1'b1, 8'h00);
        send_byte(SKIP_CHAR, 1'b0, 8'h05);
        send_byte(8'h61, 1'b0, 8'h05);
        send_byte(8'h62, 1'b0, 8'h05);
        send_byte(8'h63, 1'b1, 8'h05);
        send_byte(8'h41, 1'b0, 8'h10);
        send_byte(8'h42, 1'b1, 8'h10);
        send_pred(15'h0000, 8'h00);
        send_pred(15'h7FFF, 8'hFF);
        send_unknown();
        // label continues across predicate and readout
        send_byte(8'h61, 1'b0, 8'h01);
        send_pred(15'h1234, 8'h80);
        send_byte(8'h62, 1'b0, 8'h02);
        send_readout();
        send_byte(8'h63, 1'b1, 8'h03);
        send_readout();
        wait_for_words();

        // random
        while (random_done < RANDOM_ITEMS) begin
            no_gaps = (random_done >= 70 && random_done < 120);
            if (!mid_drain_done && random_done >= 100) begin
                mid_drain_done = 1'b1;
                wait_for_words();
            end
            pick = $urandom_range(99);
            if (pick < 55) begin
                len = $urandom_range(1, 9);
                send_label(len, 1'b1);
                random_done += len;
            end else if (pick < 75) begin
                send_pred($urandom_range(99) < 30 ? PRED_W'($urandom_range(15))
                                                  : PRED_W'($urandom), 8'($urandom));
                random_done++;
            end else if (pick < 87) begin
                send_readout();
                random_done++;
            end else if (pick < 95) begin
                // unterminated run that runs into the next label
                len = $urandom_range(1, 3);
                send_label(len, 1'b0);
                random_done += len;
            end else begin
                send_unknown();
                random_done++;
            end
        end
        no_gaps = 1'b0;
        send_readout();
        wait_for_words();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d label bytes, %0d predicates, %0d readouts, %0d unknown requests",
                 label_bytes, predicates, readouts, unknowns);
        $display("run: %0d signature words compared, %0d mismatches",
                 words_checked, fail_count);
        if (fail_count == 0 && pending_words == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
